>>> sv/repeating_beep_sequencer_unit_macros.svh
// Assertion macros used by the beep sequencer core module, rbs_core.
`ifndef REPEATING_BEEP_SEQUENCER_UNIT_MACROS_SVH
`define REPEATING_BEEP_SEQUENCER_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rbs_pkg.sv
// Types and constants shared by the beep sequencer modules.
package rbs_pkg;

    localparam int unsigned TIME_BITS   = 48;
    localparam int unsigned NOW_BITS    = 48;
    localparam int unsigned US_PER_MS   = 1000;
    // 65535 ms expressed in microseconds fits in 26 bits.
    localparam int unsigned MS_US_BITS  = 26;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [MS_US_BITS-1:0] dur_us_t;

    typedef struct packed {
        logic     mode;
        time_t    now;
        logic [2:0] leds;
        logic [7:0] count;
        dur_us_t  on_us;
        dur_us_t  gap_us;
    } item_t;

    typedef struct packed {
        logic [2:0] leds;
        logic       buzzer;
        logic       busy;
    } result_t;

endpackage

>>> sv/repeating_beep_sequencer_unit.sv
// Top level of the repeating beep sequencer: stream ports, input and result registers.
// Items pass the input register, then the result register. While m_tready is high,
// throughput is one item per cycle; each item is one pass through the compare, the
// deadline adder and the beep counter in rbs_core. A stalled master side holds the
// input register, which then keeps one item. Reset (rst_n, asynchronous, active low)
// empties both registers, stops any pattern, and turns the buzzer and all LEDs off.
module repeating_beep_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: now_us[47:0], red level, green level, blue level,
    // beep count[7:0], on_ms[15:0], gap_ms[15:0], zero fill up to bit 95.
    input  logic [95:0] s_tdata,
    // Fields from bit 0: mode (0 = time tick, 1 = start a new pattern).
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: red, green, blue, buzzer, busy_res, zero fill.
    output logic [7:0]  m_tdata
);
    import rbs_pkg::*;

    logic     in_valid_reg, in_valid_next;
    item_t    in_item_reg;
    item_t    in_item_next;
    logic     out_valid_reg, out_valid_next;
    result_t  out_result_reg;
    result_t  core_result;

    logic     s_xfer;
    logic     step;

    // The held item is processed whenever the result register is free or drains now.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_xfer   = s_tvalid && s_tready;

    // Millisecond durations are scaled to microseconds on the way in, so the
    // processing pass only has to add.
    always_comb
    begin
        in_item_next.mode   = s_tuser;
        in_item_next.now    = TIME_BITS'(s_tdata[NOW_BITS-1:0]);
        in_item_next.leds   = s_tdata[50:48];
        in_item_next.count  = s_tdata[58:51];
        in_item_next.on_us  = MS_US_BITS'(32'(s_tdata[74:59]) * US_PER_MS);
        in_item_next.gap_us = MS_US_BITS'(32'(s_tdata[90:75]) * US_PER_MS);
    end

    always_comb
    begin
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_item_reg <= in_item_next;
        end
        if (step)
        begin
            out_result_reg <= core_result;
        end
    end

    rbs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .result (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.busy, out_result_reg.buzzer,
                       out_result_reg.leds};

endmodule

>>> sv/rbs_core.sv
// Pattern state registers and the combinational next-state logic of the beep sequencer.
module rbs_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  rbs_pkg::item_t  item,
    output rbs_pkg::result_t result
);
    import rbs_pkg::*;

    `include "repeating_beep_sequencer_unit_macros.svh"

    logic       running_reg, running_next;
    logic       buzzer_reg, buzzer_next;
    logic [7:0] beeps_reg, beeps_next;
    time_t      deadline_reg, deadline_next;
    dur_us_t    on_us_reg, on_us_next;
    dur_us_t    gap_us_reg, gap_us_next;
    logic [2:0] leds_reg, leds_next;

    logic                 is_start;
    logic                 fire;
    logic [7:0]           beeps_dec;
    dur_us_t              addend;
    logic [TIME_BITS:0]   sum;
    time_t                armed;

    assign is_start  = (item.mode == MODE_START);
    assign fire      = running_reg && (item.now >= deadline_reg);
    assign beeps_dec = (beeps_reg != 8'd0) ? beeps_reg - 8'd1 : 8'd0;

    // One adder arms every deadline; the gap is used only when a beep ends.
    always_comb
    begin
        if (is_start)
        begin
            addend = item.on_us;
        end
        else if (buzzer_reg)
        begin
            addend = gap_us_reg;
        end
        else
        begin
            addend = on_us_reg;
        end
    end

    // Deadlines past the largest time value saturate.
    assign sum   = {1'b0, item.now} + (TIME_BITS + 1)'(addend);
    assign armed = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

    always_comb
    begin
        running_next  = running_reg;
        buzzer_next   = buzzer_reg;
        beeps_next    = beeps_reg;
        deadline_next = deadline_reg;
        on_us_next    = on_us_reg;
        gap_us_next   = gap_us_reg;
        leds_next     = leds_reg;
        if (is_start)
        begin
            leds_next     = item.leds;
            beeps_next    = item.count;
            on_us_next    = item.on_us;
            gap_us_next   = item.gap_us;
            running_next  = (item.count != 8'd0);
            buzzer_next   = (item.count != 8'd0);
            deadline_next = armed;
        end
        else if (fire)
        begin
            if (buzzer_reg)
            begin
                buzzer_next   = 1'b0;
                deadline_next = armed;
            end
            else
            begin
                beeps_next = beeps_dec;
                if (beeps_dec == 8'd0)
                begin
                    running_next = 1'b0;
                end
                else
                begin
                    buzzer_next   = 1'b1;
                    deadline_next = armed;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            buzzer_reg   <= 1'b0;
            beeps_reg    <= 8'd0;
            deadline_reg <= '0;
            on_us_reg    <= '0;
            gap_us_reg   <= '0;
            leds_reg     <= 3'b000;
        end
        else if (step)
        begin
            running_reg  <= running_next;
            buzzer_reg   <= buzzer_next;
            beeps_reg    <= beeps_next;
            deadline_reg <= deadline_next;
            on_us_reg    <= on_us_next;
            gap_us_reg   <= gap_us_next;
            leds_reg     <= leds_next;
        end
    end

    assign result.leds   = leds_next;
    assign result.buzzer = buzzer_next;
    assign result.busy   = running_next;

    `RBS_ASSERT_SAME(a_busy_has_beeps, clk, rst_n, running_reg, beeps_reg != 8'd0,
        "running pattern with no beeps left")
    `RBS_ASSERT_SAME(a_idle_is_quiet, clk, rst_n, !running_reg, !buzzer_reg,
        "buzzer on while no pattern runs")
    `RBS_ASSERT_NEXT(a_idle_tick_holds, clk, rst_n,
        step && !is_start && !running_reg,
        $stable(deadline_reg) && $stable(beeps_reg) && !running_reg,
        "tick while idle changed the pattern state")
    `RBS_ASSERT_NEXT(a_zero_start_idle, clk, rst_n,
        step && is_start && (item.count == 8'd0),
        !running_reg && !buzzer_reg,
        "start with zero beeps left a pattern running")

endmodule
